FILE: rtl/lbw_pkg.sv
// ----------------------------------------------------------------------------
// lbw_pkg
// Shared types and constants for the LFSR byte whitener.
// ----------------------------------------------------------------------------
package lbw_pkg;

   localparam int unsigned StateWidth  = 32;
   localparam int unsigned OrderWidth  = 6;
   localparam int unsigned PosWidth    = 5;
   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned BitsPerItem = 8;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [StateWidth-1:0] ResetTapMask = 32'h0000_0021;
   localparam logic [StateWidth-1:0] ResetSeed    = 32'h0000_01ff;
   localparam logic [OrderWidth-1:0] ResetOrder   = 6'd9;

   typedef enum logic [1:0] {
      OP_WHITEN = 2'd0,
      OP_BIT    = 2'd1,
      OP_RESEED = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_TAP_MASK = 2'd0,
      CSR_SEED     = 2'd1,
      CSR_ORDER    = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [StateWidth-1:0] tap_mask;
      logic [PosWidth-1:0]   insert_pos;
   } lfsr_cfg_type;

   typedef struct packed {
      logic [StateWidth-1:0] state_one;
      logic [StateWidth-1:0] state_all;
      logic [ByteWidth-1:0]  packed_bits;
      logic                  first_bit;
   } step_res_type;

endpackage

FILE: rtl/lbw_step.sv
// ----------------------------------------------------------------------------
// lbw_step
// Unrolled LFSR bit steps: state after one step and after a full byte,
// plus the output bits packed MSB-first.
// ----------------------------------------------------------------------------
module lbw_step (
   input  logic [lbw_pkg::StateWidth-1:0] state,
   input  lbw_pkg::lfsr_cfg_type          cfg,
   output lbw_pkg::step_res_type          res
);

   logic [lbw_pkg::StateWidth-1:0] st [lbw_pkg::BitsPerItem+1];

   always_comb begin
      st[0] = state;
      for (int i = 0; i < lbw_pkg::BitsPerItem; i++) begin
         // feedback is OR'ed in; bits above the insert point are kept
         st[i+1] = (st[i] >> 1) |
                   ({{(lbw_pkg::StateWidth-1){1'b0}}, ^(st[i] & cfg.tap_mask)}
                    << cfg.insert_pos);
      end
   end

   always_comb begin
      res.state_one = st[1];
      res.state_all = st[lbw_pkg::BitsPerItem];
      res.first_bit = st[0][0];
      for (int i = 0; i < lbw_pkg::BitsPerItem; i++) begin
         res.packed_bits[lbw_pkg::ByteWidth-1-i] = st[i][0];
      end
   end

endmodule

FILE: rtl/lfsr_byte_whitener.sv
// ----------------------------------------------------------------------------
// lfsr_byte_whitener
// Fibonacci LFSR data whitener: whiten a byte, emit one generator bit, or
// reload the seed.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  request  | req_valid req_stall req_op req_data_byte| in
//  response | rsp_valid rsp_stall rsp_result_value    | out
//  csr      | csr_write_enable csr_index csr_write_data| in
//
// One request per cycle while req_stall is low; an accepted request passes the input
// register, then the response register after the unrolled 8-step LFSR.
// Reseed and unused op codes give no response; reseed loads the seed in order.
// Reset is synchronous; state resets to the seed reset value.
// req_stall is raised only while a response is held by rsp_stall.
// ----------------------------------------------------------------------------
module lfsr_byte_whitener (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic [lbw_pkg::ByteWidth-1:0]       req_data_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [lbw_pkg::ByteWidth-1:0]       rsp_result_value,
   input  logic                                csr_write_enable,
   input  logic [lbw_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [lbw_pkg::StateWidth-1:0]      csr_write_data
);

   logic [lbw_pkg::StateWidth-1:0] tap_mask_ff;
   logic [lbw_pkg::StateWidth-1:0] seed_ff;
   logic [lbw_pkg::OrderWidth-1:0] order_ff;
   logic [lbw_pkg::StateWidth-1:0] state_ff, state_in;

   logic                           s1_valid_ff, s1_valid_in;
   lbw_pkg::op_type                s1_op_ff;
   logic [lbw_pkg::ByteWidth-1:0]  s1_data_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [lbw_pkg::ByteWidth-1:0]  rsp_value_ff, rsp_value_in;

   logic                           advance;
   logic                           req_take;
   logic [lbw_pkg::PosWidth-1:0]   insert_pos;
   lbw_pkg::lfsr_cfg_type          step_cfg;
   lbw_pkg::step_res_type          step_res;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_mask_ff <= lbw_pkg::ResetTapMask;
         seed_ff     <= lbw_pkg::ResetSeed;
         order_ff    <= lbw_pkg::ResetOrder;
      end else if (csr_write_enable) begin
         unique case (lbw_pkg::csr_idx_type'(csr_index))
            lbw_pkg::CSR_TAP_MASK: tap_mask_ff <= csr_write_data;
            lbw_pkg::CSR_SEED:     seed_ff     <= csr_write_data;
            lbw_pkg::CSR_ORDER:    order_ff    <= csr_write_data[lbw_pkg::OrderWidth-1:0];
            default: ;
         endcase
      end
   end

   // order clamped to 1..32, insert position is order-1
   always_comb begin
      if (order_ff == '0) begin
         insert_pos = '0;
      end else if (order_ff > lbw_pkg::OrderWidth'(lbw_pkg::StateWidth)) begin
         insert_pos = lbw_pkg::PosWidth'(lbw_pkg::StateWidth - 1);
      end else begin
         insert_pos = lbw_pkg::PosWidth'(order_ff - 1'b1);
      end
   end

   assign step_cfg.tap_mask   = tap_mask_ff;
   assign step_cfg.insert_pos = insert_pos;

   lbw_step u_step (
      .state (state_ff),
      .cfg   (step_cfg),
      .res   (step_res)
   );

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // an empty input stage takes a request even while the response is held
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance || !s1_valid_ff) begin
         s1_valid_in = req_take;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      if (s1_valid_ff && advance) begin
         case (s1_op_ff)
            lbw_pkg::OP_WHITEN: begin
               state_in     = step_res.state_all;
               rsp_valid_in = 1'b1;
               rsp_value_in = s1_data_ff ^ step_res.packed_bits;
            end
            lbw_pkg::OP_BIT: begin
               state_in     = step_res.state_one;
               rsp_valid_in = 1'b1;
               rsp_value_in = {{(lbw_pkg::ByteWidth-1){1'b0}}, step_res.first_bit};
            end
            lbw_pkg::OP_RESEED: begin
               state_in = seed_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbw_pkg::ResetSeed;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= lbw_pkg::op_type'(req_op);
         s1_data_ff <= req_data_byte;
      end
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

endmodule

FILE: rtl/lbw_checker.sv
// ----------------------------------------------------------------------------
// lbw_checker
// Port-level checks for the LFSR byte whitener, bound to the top level.
// ----------------------------------------------------------------------------
module lbw_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [1:0]                          req_op,
   input logic [lbw_pkg::ByteWidth-1:0]       req_data_byte,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [lbw_pkg::ByteWidth-1:0]       rsp_result_value
);

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("response changed while stalled");

   // stalled request keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=>
         req_valid && $stable(req_op) && $stable(req_data_byte))
      else $error("request changed while stalled");

   // back-pressure only comes from a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a held response");

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

endmodule

bind lfsr_byte_whitener lbw_checker u_lbw_checker (.*);

FILE: tb/lfsr_byte_whitener_tb.sv
// ----------------------------------------------------------------------------
// lfsr_byte_whitener_tb
// Self-checking bench for the LFSR byte whitener. A directed table covers
// reset state, register extremes, reseed and the unused op code. Four random
// phases follow, each with its own register setting and idle/stall pattern.
// Every response is compared with a bit-level model of the shift register or a table literal.
// ----------------------------------------------------------------------------
module lfsr_byte_whitener_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PipeDepth   = 2;
   localparam int PhaseItems  = 220;

   typedef enum logic {
      ROW_REQ,
      ROW_CSR
   } row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      lbw_pkg::op_type                 op;
      lbw_pkg::csr_idx_type            idx;
      logic [lbw_pkg::StateWidth-1:0]  value;
      bit                              has_lit;
      logic [lbw_pkg::ByteWidth-1:0]   lit;
   } stim_row_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   lbw_pkg::op_type                 req_op = lbw_pkg::OP_WHITEN;
   logic [lbw_pkg::ByteWidth-1:0]   req_data_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [lbw_pkg::ByteWidth-1:0]   rsp_result_value;
   logic                            csr_write_enable = 1'b0;
   lbw_pkg::csr_idx_type            csr_index = lbw_pkg::CSR_TAP_MASK;
   logic [lbw_pkg::StateWidth-1:0]  csr_write_data = '0;

   // model copy of the block's registers and shift state
   logic [lbw_pkg::StateWidth-1:0]  lfsr_state = lbw_pkg::ResetSeed;
   logic [lbw_pkg::StateWidth-1:0]  tap_mask_q = lbw_pkg::ResetTapMask;
   logic [lbw_pkg::StateWidth-1:0]  seed_q     = lbw_pkg::ResetSeed;
   logic [lbw_pkg::OrderWidth-1:0]  order_q    = lbw_pkg::ResetOrder;

   logic [lbw_pkg::ByteWidth-1:0]   expected_bytes[$];
   stim_row_type                    stim_rows[$];
   int                              fail_count = 0;
   int                              req_idle_pct = 0;
   int                              rsp_stall_pct = 0;

   lfsr_byte_whitener dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one bit step: emit bit 0, shift right, insert tap parity at order-1
   function automatic logic lfsr_advance();
      logic out_bit;
      logic fb;
      int   pos;
      out_bit = lfsr_state[0];
      fb      = ^(lfsr_state & tap_mask_q);
      if (order_q == '0)
         pos = 0;
      else if (order_q > 6'd32)
         pos = 31;
      else
         pos = int'(order_q) - 1;
      lfsr_state = (lfsr_state >> 1) | ({31'b0, fb} << pos);
      return out_bit;
   endfunction

   function automatic bit predict_whitener(input lbw_pkg::op_type op,
                                           input logic [lbw_pkg::ByteWidth-1:0] data,
                                           output logic [lbw_pkg::ByteWidth-1:0] res);
      logic [lbw_pkg::ByteWidth-1:0] pn_byte;
      pn_byte = '0;
      res     = '0;
      case (op)
         lbw_pkg::OP_WHITEN: begin
            for (int i = 0; i < lbw_pkg::BitsPerItem; i++)
               pn_byte = {pn_byte[lbw_pkg::ByteWidth-2:0], lfsr_advance()};
            res = data ^ pn_byte;
            return 1'b1;
         end
         lbw_pkg::OP_BIT: begin
            res = {7'b0, lfsr_advance()};
            return 1'b1;
         end
         lbw_pkg::OP_RESEED: begin
            lfsr_state = seed_q;
            return 1'b0;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   function automatic void add_req(lbw_pkg::op_type op, logic [lbw_pkg::ByteWidth-1:0] data,
                                   bit has_lit = 1'b0,
                                   logic [lbw_pkg::ByteWidth-1:0] lit = '0);
      stim_row_type r;
      r.kind    = ROW_REQ;
      r.op      = op;
      r.idx     = lbw_pkg::CSR_TAP_MASK;
      r.value   = {24'b0, data};
      r.has_lit = has_lit;
      r.lit     = lit;
      stim_rows.push_back(r);
   endfunction

   function automatic void add_csr(lbw_pkg::csr_idx_type idx,
                                   logic [lbw_pkg::StateWidth-1:0] value);
      stim_row_type r;
      r.kind    = ROW_CSR;
      r.op      = lbw_pkg::OP_NONE;
      r.idx     = idx;
      r.value   = value;
      r.has_lit = 1'b0;
      r.lit     = '0;
      stim_rows.push_back(r);
   endfunction

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
      // reseed / unused ops may still be in the pipe
      repeat (PipeDepth + 2) @(posedge clock);
   endtask

   task automatic write_csr(lbw_pkg::csr_idx_type idx, logic [lbw_pkg::StateWidth-1:0] value);
      wait_for_drain();
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         lbw_pkg::CSR_TAP_MASK: tap_mask_q = value;
         lbw_pkg::CSR_SEED:     seed_q = value;
         lbw_pkg::CSR_ORDER:    order_q = value[lbw_pkg::OrderWidth-1:0];
         default:               ;
      endcase
   endtask

   task automatic issue_request(lbw_pkg::op_type op, logic [lbw_pkg::ByteWidth-1:0] data,
                                bit has_lit, logic [lbw_pkg::ByteWidth-1:0] lit);
      logic [lbw_pkg::ByteWidth-1:0] res;
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      // accepted at this edge
      if (predict_whitener(op, data, res))
         expected_bytes.push_back(has_lit ? lit : res);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // response side: sample handshake, check, then pick next stall
   always @(posedge clock) begin
      logic [lbw_pkg::ByteWidth-1:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual %h",
                     $time, rsp_result_value);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            if (want !== rsp_result_value) begin
               $display("%0t: result_value mismatch: expected %h, actual %h",
                        $time, want, rsp_result_value);
               fail_count++;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      lbw_pkg::op_type               op;
      logic [lbw_pkg::ByteWidth-1:0] data;
      int                            n;
      int                            r;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      add_req(lbw_pkg::OP_WHITEN, 8'h00, 1'b1, 8'hff);    // PN9 opens with 0xff
      add_req(lbw_pkg::OP_BIT,    8'h00);
      add_req(lbw_pkg::OP_WHITEN, 8'hff);
      add_req(lbw_pkg::OP_WHITEN, 8'ha5);
      add_req(lbw_pkg::OP_NONE,   8'h3c);                 // must not touch the state
      add_req(lbw_pkg::OP_BIT,    8'hff);
      add_req(lbw_pkg::OP_RESEED, 8'h55);
      add_req(lbw_pkg::OP_WHITEN, 8'h00, 1'b1, 8'hff);
      add_csr(lbw_pkg::CSR_SEED,     32'h0000_0000);
      add_csr(lbw_pkg::CSR_TAP_MASK, 32'h0000_0000);
      add_req(lbw_pkg::OP_RESEED, 8'h00);
      add_req(lbw_pkg::OP_WHITEN, 8'h5a, 1'b1, 8'h5a);    // zero state passes data through
      add_req(lbw_pkg::OP_BIT,    8'h00, 1'b1, 8'h00);
      add_csr(lbw_pkg::CSR_TAP_MASK, 32'hffff_ffff);
      add_csr(lbw_pkg::CSR_SEED,     32'hffff_ffff);
      add_csr(lbw_pkg::CSR_ORDER,    32'd32);
      add_req(lbw_pkg::OP_RESEED, 8'h00);
      add_req(lbw_pkg::OP_WHITEN, 8'h0f, 1'b1, 8'hf0);    // low byte of all-ones seed
      add_req(lbw_pkg::OP_BIT,    8'h00);
      add_csr(lbw_pkg::CSR_ORDER,    32'd0);              // behaves as order 1
      add_req(lbw_pkg::OP_WHITEN, 8'h81);
      add_req(lbw_pkg::OP_BIT,    8'h00);
      add_csr(lbw_pkg::CSR_ORDER,    32'hffff_ffff);      // only low 6 bits kept: 63
      add_req(lbw_pkg::OP_WHITEN, 8'h7e);
      add_req(lbw_pkg::OP_BIT,    8'h00);
      add_csr(lbw_pkg::CSR_UNUSED,   32'hdead_beef);
      add_req(lbw_pkg::OP_WHITEN, 8'h01);
      add_csr(lbw_pkg::CSR_ORDER,    32'd1);
      add_csr(lbw_pkg::CSR_TAP_MASK, 32'h8000_0001);
      add_req(lbw_pkg::OP_RESEED, 8'h00);
      add_req(lbw_pkg::OP_WHITEN, 8'h80);
      add_req(lbw_pkg::OP_WHITEN, 8'h00);

      foreach (stim_rows[i]) begin
         if (stim_rows[i].kind == ROW_CSR)
            write_csr(stim_rows[i].idx, stim_rows[i].value);
         else
            issue_request(stim_rows[i].op, stim_rows[i].value[lbw_pkg::ByteWidth-1:0],
                          stim_rows[i].has_lit, stim_rows[i].lit);
      end

      // random phases: setting and idle pattern change per phase
      for (int phase = 0; phase < 4; phase++) begin
         wait_for_drain();
         case (phase)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
               write_csr(lbw_pkg::CSR_TAP_MASK, lbw_pkg::ResetTapMask);
               write_csr(lbw_pkg::CSR_SEED, lbw_pkg::ResetSeed);
               write_csr(lbw_pkg::CSR_ORDER, {26'b0, lbw_pkg::ResetOrder});
            end
            1: begin
               req_idle_pct  = 57;
               rsp_stall_pct = 0;
               write_csr(lbw_pkg::CSR_TAP_MASK, $urandom);
               write_csr(lbw_pkg::CSR_SEED, $urandom);
               write_csr(lbw_pkg::CSR_ORDER, $urandom_range(32, 1));
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 57;
               write_csr(lbw_pkg::CSR_TAP_MASK, $urandom);
               write_csr(lbw_pkg::CSR_SEED, 32'hffff_ffff);
               write_csr(lbw_pkg::CSR_ORDER, 32'd63);
            end
            default: begin
               req_idle_pct  = 24;
               rsp_stall_pct = 24;
               write_csr(lbw_pkg::CSR_TAP_MASK, $urandom);
               write_csr(lbw_pkg::CSR_SEED, $urandom);
               write_csr(lbw_pkg::CSR_ORDER, 32'd0);
            end
         endcase

         n = 0;
         while (n < PhaseItems) begin
            r = $urandom_range(99);
            if (r < 60)
               op = lbw_pkg::OP_WHITEN;
            else if (r < 85)
               op = lbw_pkg::OP_BIT;
            else if (r < 95)
               op = lbw_pkg::OP_RESEED;
            else
               op = lbw_pkg::OP_NONE;
            data = $urandom_range(255);
            // hold off mid-phase until the pipe is empty
            if (n == PhaseItems / 2)
               wait_for_drain();
            issue_request(op, data, 1'b0, '0);
            if (op != lbw_pkg::OP_NONE)
               n++;
         end
      end

      wait_for_drain();
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
